// ----- sv/hamdec_pkg.sv -----
package hamdec_pkg;

	localparam int CODE_BITS       = 31;
	localparam int DATA_BITS       = 26;
	localparam int WORDS_PER_BLOCK = 8;
	localparam int BYTES_IN        = 31;
	localparam int BYTES_OUT       = 26;
	localparam int BLOCK_BITS      = DATA_BITS * WORDS_PER_BLOCK;
	localparam int SYN_BITS        = $clog2(CODE_BITS + 1);
	localparam int WIDX_BITS       = $clog2(WORDS_PER_BLOCK);
	localparam int HELD_BITS       = $clog2(CODE_BITS);
	localparam int BCNT_BITS       = $clog2(BYTES_IN);
	localparam int OCNT_BITS       = $clog2(BYTES_OUT + 1);
	localparam int CORR_BITS       = 4;

	// codeword closes on this byte when at least this many bits are already held
	localparam int CLOSE_AT = CODE_BITS - 8;

	typedef logic [CODE_BITS-1:0]  code_t;
	typedef logic [DATA_BITS-1:0]  data_t;
	typedef logic [BLOCK_BITS-1:0] block_t;

	typedef struct packed {
		data_t data;
		logic  fixed;
	} dec_t;

	function automatic dec_t decode_word(input code_t code);
		logic [SYN_BITS-1:0] syn;
		code_t               fixed_code;
		dec_t                res;
		int                  j;
		syn = '0;
		for (int p = 1; p <= CODE_BITS; p++) begin
			if (code[p-1])
				syn = syn ^ SYN_BITS'(p);
		end
		fixed_code = code;
		for (int p = 1; p <= CODE_BITS; p++) begin
			if (syn == SYN_BITS'(p))
				fixed_code[p-1] = ~code[p-1];
		end
		// data positions are the ones that are not powers of two
		res.data = '0;
		j = 0;
		for (int p = 1; p <= CODE_BITS; p++) begin
			if ((p & (p - 1)) != 0) begin
				res.data[j] = fixed_code[p-1];
				j++;
			end
		end
		res.fixed = (syn != '0);
		return res;
	endfunction

endpackage

// ----- sv/hamming_31_26_block_decoder_unit.sv -----
// The first decoded byte of a block is offered the cycle after its
// 31st coded byte is taken; the other 25 follow one per cycle if not stalled.
// When not stalled: one coded byte per cycle in, one decoded byte per cycle out.
// The 31st byte of a block waits only while bytes of the previous block
// are still in the output shift register.
// Reset (arst_n low, asynchronous): counters and output valid cleared; the
// decoded word store holds no reset value and is always refilled per block.
module hamming_31_26_block_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          last_of_block,
	output logic [hamdec_pkg::CORR_BITS-1:0] block_corrections
);
	import hamdec_pkg::*;

	code_t                 acc_q;
	logic [HELD_BITS-1:0]  held_q;
	logic [WIDX_BITS-1:0]  widx_q;
	logic [BCNT_BITS-1:0]  bcnt_q;
	logic [CORR_BITS-1:0]  corr_q;
	data_t                 words_q [WORDS_PER_BLOCK];

	block_t                ob_q;
	logic [OCNT_BITS-1:0]  ocnt_q;
	logic [CORR_BITS-1:0]  ocorr_q;

	logic                  in_acc;
	logic                  out_acc;
	logic                  closes;
	logic                  block_done;
	logic [2:0]            rem;
	logic [CODE_BITS+7:0]  ext;
	code_t                 code;
	dec_t                  dec;
	logic [CORR_BITS-1:0]  corr_next;
	block_t                blk;

	assign in_stall   = (bcnt_q == BCNT_BITS'(BYTES_IN - 1)) && (ocnt_q != '0);
	assign in_acc     = in_valid && !in_stall;
	assign out_valid  = (ocnt_q != '0);
	assign out_acc    = out_valid && !out_stall;
	assign block_done = in_acc && (bcnt_q == BCNT_BITS'(BYTES_IN - 1));

	assign out_byte          = ob_q[BLOCK_BITS-1 -: 8];
	assign last_of_block     = (ocnt_q == OCNT_BITS'(1));
	assign block_corrections = ocorr_q;

	// bits past the closing codeword spill into the next one
	assign closes = (held_q >= HELD_BITS'(CLOSE_AT));
	assign rem    = 3'(held_q - HELD_BITS'(CLOSE_AT));
	assign ext    = {acc_q, in_byte};
	assign code   = code_t'(ext >> rem);
	assign dec    = decode_word(code);

	always_comb begin
		corr_next = corr_q;
		if (closes && dec.fixed && corr_q != '1)
			corr_next = corr_q + CORR_BITS'(1);
	end

	always_comb begin
		blk = '0;
		for (int i = 0; i < WORDS_PER_BLOCK - 1; i++)
			blk[i*DATA_BITS +: DATA_BITS] = words_q[i];
		blk[BLOCK_BITS-1 -: DATA_BITS] = dec.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			widx_q <= '0;
			bcnt_q <= '0;
			corr_q <= '0;
		end else if (in_acc) begin
			if (block_done) begin
				acc_q  <= '0;
				held_q <= '0;
				widx_q <= '0;
				bcnt_q <= '0;
				corr_q <= '0;
			end else begin
				bcnt_q <= bcnt_q + BCNT_BITS'(1);
				corr_q <= corr_next;
				if (closes) begin
					acc_q  <= code_t'(in_byte & ((8'd1 << rem) - 8'd1));
					held_q <= HELD_BITS'(rem);
					widx_q <= widx_q + WIDX_BITS'(1);
				end else begin
					acc_q  <= code_t'(ext);
					held_q <= held_q + HELD_BITS'(8);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && closes)
			words_q[widx_q] <= dec.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
		end else if (block_done) begin
			ocnt_q <= OCNT_BITS'(BYTES_OUT);
		end else if (out_acc) begin
			ocnt_q <= ocnt_q - OCNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (block_done) begin
			ob_q    <= blk;
			ocorr_q <= corr_next;
		end else if (out_acc) begin
			ob_q <= ob_q << 8;
		end
	end

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		block_done |-> (ocnt_q == '0))
		else $error("block finished while previous output still pending");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		block_done |=> (out_valid && ocnt_q == OCNT_BITS'(BYTES_OUT)))
		else $error("finished block not loaded for output");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_of_block) |=> !out_valid)
		else $error("output still valid after last byte of block");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q < HELD_BITS'(CODE_BITS))
		else $error("held bit count out of range");
`endif

endmodule
